/* hdl/sdi_pkg.sv */
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types, codes and the command frame table for the SD card SPI-mode
// init sequencer.
// ----------------------------------------------------------------------------
package sdi_pkg;

   // request kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_OK   = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   // card path codes
   localparam logic [1:0] PATH_UNKNOWN = 2'd0;
   localparam logic [1:0] PATH_V2      = 2'd1;
   localparam logic [1:0] PATH_V1_ACMD = 2'd2;
   localparam logic [1:0] PATH_V1_CMD1 = 2'd3;

   // command indexes
   localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
   localparam logic [5:0] CMD_SEND_OP   = 6'd1;
   localparam logic [5:0] CMD_IF_COND   = 6'd8;
   localparam logic [5:0] CMD_APP_OP    = 6'd41;
   localparam logic [5:0] CMD_APP       = 6'd55;
   localparam logic [5:0] CMD_READ_OCR  = 6'd58;

   // R1 values and bus bytes
   localparam logic [7:0] R1_READY   = 8'h00;
   localparam logic [7:0] R1_IDLE    = 8'h01;
   localparam logic [7:0] R1_ILLEGAL = 8'h05;
   localparam logic [7:0] BYTE_FILL  = 8'hFF;

   localparam logic [7:0]  FRAME_START  = 8'h40;
   localparam logic [7:0]  FRAME_STOP   = 8'h01;
   localparam logic [7:0]  CRC_GO_IDLE  = 8'h94;
   localparam logic [7:0]  CRC_IF_COND  = 8'h86;
   localparam logic [7:0]  CRC_SEND_OP  = 8'hF9;
   localparam logic [7:0]  CRC_APP_OP   = 8'hE5;
   localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
   localparam logic [2:0]  FRAME_LAST   = 3'd5;
   localparam logic [2:0]  TRAIL_BYTES  = 3'd4;

   // configuration register indexes and reset values
   localparam int         CSR_ADDR_W          = 2;
   localparam int         CSR_DATA_W          = 16;
   localparam logic [1:0] REG_POLL_LIMIT      = 2'd0;
   localparam logic [1:0] REG_RETRY_TICKS     = 2'd1;
   localparam logic [1:0] REG_FILL_BYTES      = 2'd2;
   localparam logic [7:0]  POLL_LIMIT_RST     = 8'd8;
   localparam logic [15:0] RETRY_TICKS_RST    = 16'd10000;
   localparam logic [7:0]  FILL_BYTES_RST     = 8'd11;

   typedef struct packed {
      logic [7:0]  poll_limit;
      logic [15:0] retry_delay_ticks;
      logic [7:0]  powerup_fill_bytes;
   } cfg_type;

   typedef struct packed {
      logic       has_result;
      logic [7:0] tx_byte;
      logic       select_card;
      logic [1:0] status;
   } rsp_type;

   // one byte of a six-byte command frame
   function automatic logic [7:0] frame_byte(input logic [5:0] cmd, input logic [1:0] path,
                                             input logic [2:0] pos);
      logic [31:0] arg;
      logic [7:0]  crc;
      arg = '0;
      crc = '0;
      if (cmd == CMD_IF_COND) begin
         arg = ARG_IF_COND;
         crc = CRC_IF_COND;
      end else if (cmd == CMD_GO_IDLE) begin
         crc = CRC_GO_IDLE;
      end else if (cmd == CMD_SEND_OP) begin
         crc = CRC_SEND_OP;
      end else if (cmd == CMD_APP_OP) begin
         if (path == PATH_V2) arg = ARG_HCS;
         else crc = CRC_APP_OP;
      end
      case (pos)
         3'd0: frame_byte = FRAME_START | {2'b00, cmd};
         3'd1: frame_byte = arg[31:24];
         3'd2: frame_byte = arg[23:16];
         3'd3: frame_byte = arg[15:8];
         3'd4: frame_byte = arg[7:0];
         default: frame_byte = crc | FRAME_STOP;
      endcase
   endfunction

endpackage

/* hdl/sdi_if.sv */
// ----------------------------------------------------------------------------
// sdi request and response channels
// Valid/ready channels carrying sequencer events in and bus bytes out.
// ----------------------------------------------------------------------------
interface sdi_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface sdi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       select_card;
   logic [1:0] status;

   modport source (output valid, output tx_byte, output select_card, output status,
                   input ready);
   modport sink (input valid, input tx_byte, input select_card, input status,
                 output ready);
endinterface

/* hdl/sdi_core.sv */
// ----------------------------------------------------------------------------
// sdi_core
// Init sequence state machine: one event in, at most one bus byte or final
// status out, state updated when step is high.
// ----------------------------------------------------------------------------
module sdi_core
   import sdi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [1:0] kind,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output rsp_type    res
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_FILL, PH_PRESEL, PH_FRAME, PH_POLL, PH_TRAIL, PH_DELAY, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE, ACT_CMD, ACT_FINISH, ACT_DELAY, ACT_RETRY
   } act_op_type;

   typedef struct packed {
      act_op_type op;
      logic [5:0] cmd;
      logic       ok;
      logic       path_we;
      logic [1:0] path;
   } act_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  cmd_ff, cmd_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] delay_ff, delay_in;
   logic [1:0]  path_ff, path_in;

   function automatic act_type acmd_result(input logic [1:0] path, input logic [7:0] r1);
      act_type a;
      a = '{op: ACT_FINISH, cmd: CMD_GO_IDLE, ok: 1'b0, path_we: 1'b0, path: PATH_UNKNOWN};
      if (r1 == R1_IDLE) begin
         a.op = ACT_DELAY;
      end else if (path == PATH_V2) begin
         if (r1 == R1_READY) begin
            a.op  = ACT_CMD;
            a.cmd = CMD_READ_OCR;
         end
      end else if (r1 == R1_READY) begin
         a.ok = 1'b1;
      end else if (r1 == R1_ILLEGAL) begin
         // old card rejects ACMD41, fall back to CMD1
         a.op      = ACT_CMD;
         a.cmd     = CMD_SEND_OP;
         a.path_we = 1'b1;
         a.path    = PATH_V1_CMD1;
      end
      return a;
   endfunction

   function automatic act_type decide(input logic [5:0] cmd, input logic [1:0] path,
                                      input logic [7:0] r1);
      act_type a;
      a = '{op: ACT_FINISH, cmd: CMD_GO_IDLE, ok: 1'b0, path_we: 1'b0, path: PATH_UNKNOWN};
      case (cmd)
         CMD_GO_IDLE: begin
            if (r1 == R1_IDLE) begin
               a.op  = ACT_CMD;
               a.cmd = CMD_IF_COND;
            end
         end
         CMD_IF_COND: begin
            if (r1 == R1_IDLE || r1 == R1_ILLEGAL) begin
               a.op      = ACT_CMD;
               a.cmd     = CMD_APP;
               a.path_we = 1'b1;
               a.path    = (r1 == R1_IDLE) ? PATH_V2 : PATH_V1_ACMD;
            end
         end
         CMD_APP: begin
            if (r1 == R1_IDLE) begin
               a.op  = ACT_CMD;
               a.cmd = CMD_APP_OP;
            end else begin
               a = acmd_result(path, r1);
            end
         end
         CMD_APP_OP: begin
            a = acmd_result(path, r1);
         end
         CMD_SEND_OP: begin
            if (r1 == R1_IDLE) a.op = ACT_DELAY;
            else a.ok = (r1 == R1_READY);
         end
         default: begin
            a.ok = (r1 == R1_READY);
         end
      endcase
      return a;
   endfunction

   always_comb begin
      act_type    act;
      logic       got;
      logic       start;
      logic [7:0] r1;
      logic [7:0] cnt;
      logic [7:0] lim;
      logic [15:0] dly;
      logic [2:0] pos_nx;
      logic [5:0] start_cmd;
      logic [5:0] retry_cmd;
      logic [1:0] path_now;

      act       = '{op: ACT_NONE, cmd: CMD_GO_IDLE, ok: 1'b0, path_we: 1'b0,
                    path: PATH_UNKNOWN};
      got       = 1'b0;
      start     = 1'b0;
      r1        = rx_byte;
      cnt       = count_ff + 8'd1;
      lim       = (cfg.powerup_fill_bytes == 8'd0) ? 8'd1 : cfg.powerup_fill_bytes;
      dly       = (delay_ff != 16'hFFFF) ? delay_ff + 16'd1 : delay_ff;
      pos_nx    = pos_ff + 3'd1;
      start_cmd = CMD_GO_IDLE;

      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      delay_in = delay_ff;
      path_in  = path_ff;
      res      = '{has_result: 1'b0, tx_byte: BYTE_FILL, select_card: 1'b0, status: ST_BUSY};

      if (kind == KIND_START) begin
         phase_in = PH_FILL;
         cmd_in   = CMD_GO_IDLE;
         pos_in   = '0;
         count_in = '0;
         delay_in = '0;
         path_in  = PATH_UNKNOWN;
         res.has_result = 1'b1;
      end else if (kind == KIND_BYTE) begin
         case (phase_ff)
            PH_FILL: begin
               count_in = cnt;
               res.has_result = 1'b1;
               if (cnt >= lim) begin
                  phase_in = PH_PRESEL;
                  res.select_card = 1'b1;
               end
            end
            PH_PRESEL: begin
               path_in = PATH_UNKNOWN;
               act.op  = ACT_CMD;
               act.cmd = CMD_GO_IDLE;
            end
            PH_FRAME: begin
               res.has_result  = 1'b1;
               res.select_card = 1'b1;
               if (pos_ff < FRAME_LAST) begin
                  pos_in      = pos_nx;
                  res.tx_byte = frame_byte(cmd_ff, path_ff, pos_nx);
               end else begin
                  phase_in = PH_POLL;
                  count_in = '0;
               end
            end
            PH_POLL: begin
               if (rx_byte != BYTE_FILL) begin
                  got = 1'b1;
               end else begin
                  count_in = cnt;
                  if (cnt >= cfg.poll_limit) begin
                     got = 1'b1;
                  end else begin
                     res.has_result  = 1'b1;
                     res.select_card = 1'b1;
                  end
               end
            end
            PH_TRAIL: begin
               pos_in = pos_nx;
               if (pos_nx < TRAIL_BYTES) begin
                  res.has_result  = 1'b1;
                  res.select_card = 1'b1;
               end else begin
                  act = decide(cmd_ff, path_ff, count_ff);
               end
            end
            default: begin
            end
         endcase
      end else if (kind == KIND_TICK && phase_ff == PH_DELAY) begin
         delay_in = dly;
         if (dly >= cfg.retry_delay_ticks) act.op = ACT_RETRY;
      end

      // R1 received: CMD8 and CMD58 clock four trailing bytes when R1 is clean
      if (got) begin
         if ((cmd_ff == CMD_IF_COND || cmd_ff == CMD_READ_OCR) && r1[7:1] == 7'd0) begin
            phase_in        = PH_TRAIL;
            count_in        = r1;
            pos_in          = '0;
            res.has_result  = 1'b1;
            res.select_card = 1'b1;
         end else begin
            act = decide(cmd_ff, path_ff, r1);
         end
      end

      path_now  = act.path_we ? act.path : path_in;
      path_in   = path_now;
      retry_cmd = (path_now == PATH_V1_CMD1) ? CMD_SEND_OP : CMD_APP;

      case (act.op)
         ACT_CMD: begin
            start     = 1'b1;
            start_cmd = act.cmd;
         end
         ACT_FINISH: begin
            phase_in       = PH_DONE;
            res.has_result = 1'b1;
            res.status     = act.ok ? ST_OK : ST_FAIL;
         end
         ACT_DELAY: begin
            phase_in = PH_DELAY;
            delay_in = '0;
            if (cfg.retry_delay_ticks == 16'd0) begin
               start     = 1'b1;
               start_cmd = retry_cmd;
            end
         end
         ACT_RETRY: begin
            start     = 1'b1;
            start_cmd = retry_cmd;
         end
         default: begin
         end
      endcase

      if (start) begin
         cmd_in          = start_cmd;
         pos_in          = '0;
         phase_in        = PH_FRAME;
         res.has_result  = 1'b1;
         res.select_card = 1'b1;
         res.tx_byte     = frame_byte(start_cmd, path_now, 3'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmd_ff   <= CMD_GO_IDLE;
         pos_ff   <= '0;
         count_ff <= '0;
         delay_ff <= '0;
         path_ff  <= PATH_UNKNOWN;
      end else if (step) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         delay_ff <= delay_in;
         path_ff  <= path_in;
      end
   end

endmodule

/* hdl/sd_spi_init_sequencer_top.sv */
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer_top
// SD card SPI-mode init sequencer with valid/ready event and byte channels.
// ----------------------------------------------------------------------------
// Each request (start, received byte, or delay tick) is taken into an input
// register and evaluated by the sequence logic once the result register is
// free or being drained; if it yields a bus byte or final status, that is
// written to the result register and offered on the response channel from
// there. One request is accepted every cycle while the result register is
// free or being drained, so a waiting result does not stop the next request
// from entering an empty input register. The user must write configuration
// through the csr port only while idle; the block does not enforce this.
module sd_spi_init_sequencer_top
   import sdi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sdi_req_if.sink               req_chan,
   sdi_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_vld_ff;
   logic [1:0] kind_ff;
   logic [7:0] rx_ff;
   logic       out_vld_ff;
   rsp_type    rsp_ff;
   rsp_type    res;
   logic       advance;

   // the stored request moves on once the result slot is free or draining
   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;

   sdi_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .kind    (kind_ff),
      .rx_byte (rx_ff),
      .cfg     (cfg_ff),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_limit         <= POLL_LIMIT_RST;
         cfg_ff.retry_delay_ticks  <= RETRY_TICKS_RST;
         cfg_ff.powerup_fill_bytes <= FILL_BYTES_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_POLL_LIMIT:  cfg_ff.poll_limit         <= csr_wdata[7:0];
            REG_RETRY_TICKS: cfg_ff.retry_delay_ticks  <= csr_wdata[15:0];
            REG_FILL_BYTES:  cfg_ff.powerup_fill_bytes <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         kind_ff <= req_chan.kind;
         rx_ff   <= req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= res.has_result;
      end else if (rsp_chan.ready) begin
         out_vld_ff <= 1'b0;
      end
      if (advance && res.has_result) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.tx_byte     = rsp_ff.tx_byte;
   assign rsp_chan.select_card = rsp_ff.select_card;
   assign rsp_chan.status      = rsp_ff.status;

endmodule

/* hdl/sdi_checker.sv */
// ----------------------------------------------------------------------------
// sdi_checker
// Port-level checks for the init sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sdi_checker
   import sdi_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_select_card,
   input logic [1:0] rsp_status
);

   logic done_ff;

   // set after a final status (and out of reset): only a start may answer next
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         done_ff <= (rsp_status != ST_BUSY);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   a_final_idle_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_BUSY |-> rsp_tx_byte == BYTE_FILL && !rsp_select_card)
      else $error("final status carries a bus transfer");

   a_start_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_ff |-> rsp_tx_byte == BYTE_FILL && !rsp_select_card &&
                               rsp_status == ST_BUSY)
      else $error("response after final status is not a restart");

   a_rsp_needs_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a request two cycles earlier");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while result slot is empty");

endmodule

bind sd_spi_init_sequencer_top sdi_checker u_sdi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_tx_byte     (rsp_chan.tx_byte),
   .rsp_select_card (rsp_chan.select_card),
   .rsp_status      (rsp_chan.status)
);

/* bench/sdi_init_check.sv */
// ----------------------------------------------------------------------------
// sdi_init_check
// Watches the request, response and csr ports of the SD SPI init sequencer,
// predicts every bus byte and final status, and compares each response in
// order with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sdi_init_check
   import sdi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sdi_req_if                    req_mon,
   sdi_rsp_if                    rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      SQ_IDLE, SQ_FILL, SQ_PRESEL, SQ_FRAME, SQ_POLL, SQ_TRAIL, SQ_DELAY, SQ_DONE
   } seq_state_e;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       select_card;
      logic [1:0] status;
   } xfer_t;

   // configuration copy
   logic [7:0]  lim_poll;
   logic [15:0] lim_ticks;
   logic [7:0]  lim_fill;

   // sequencer state copy
   seq_state_e  seq_state;
   logic [5:0]  cmd;
   logic [2:0]  fpos;
   logic [7:0]  pcnt;
   logic [15:0] dcnt;
   logic [1:0]  path;

   bit    got_xfer;
   xfer_t xfer;
   xfer_t owed_xfers[$];
   int    mismatches = 0;

   function automatic void put(input logic [7:0] tx, input logic sel, input logic [1:0] st);
      got_xfer = 1'b1;
      xfer = '{tx_byte: tx, select_card: sel, status: st};
   endfunction

   function automatic void conclude(input bit ok);
      seq_state = SQ_DONE;
      put(BYTE_FILL, 1'b0, ok ? ST_OK : ST_FAIL);
   endfunction

   function automatic logic [7:0] frame_octet(input logic [2:0] pos);
      logic [31:0] arg;
      logic [7:0]  crc;
      int          sh;
      arg = '0;
      crc = '0;
      case (cmd)
         CMD_IF_COND: begin
            arg = ARG_IF_COND;
            crc = CRC_IF_COND;
         end
         CMD_GO_IDLE: crc = CRC_GO_IDLE;
         CMD_SEND_OP: crc = CRC_SEND_OP;
         CMD_APP_OP: begin
            if (path == PATH_V2) arg = ARG_HCS;
            else crc = CRC_APP_OP;
         end
         default: ;
      endcase
      if (pos == 3'd0) return FRAME_START | {2'b00, cmd};
      if (pos >= FRAME_LAST) return crc | FRAME_STOP;
      sh = 4 - int'(pos);
      return arg[8*sh +: 8];
   endfunction

   function automatic void launch(input logic [5:0] c);
      cmd = c;
      fpos = '0;
      seq_state = SQ_FRAME;
      put(frame_octet(3'd0), 1'b1, ST_BUSY);
   endfunction

   function automatic void retry();
      launch(path == PATH_V1_CMD1 ? CMD_SEND_OP : CMD_APP);
   endfunction

   function automatic void hold_off();
      seq_state = SQ_DELAY;
      dcnt = '0;
      if (lim_ticks == '0) retry();
   endfunction

   // answer to ACMD41, or a CMD55 answer standing in for it
   function automatic void op_cond_answer(input logic [7:0] r1);
      if (r1 == R1_IDLE) hold_off();
      else if (path == PATH_V2) begin
         if (r1 == R1_READY) launch(CMD_READ_OCR);
         else conclude(1'b0);
      end else if (r1 == R1_READY) conclude(1'b1);
      else if (r1 == R1_ILLEGAL) begin
         path = PATH_V1_CMD1;
         launch(CMD_SEND_OP);
      end else conclude(1'b0);
   endfunction

   function automatic void judge(input logic [7:0] r1);
      case (cmd)
         CMD_GO_IDLE: begin
            if (r1 == R1_IDLE) launch(CMD_IF_COND);
            else conclude(1'b0);
         end
         CMD_IF_COND: begin
            if (r1 == R1_IDLE) begin
               path = PATH_V2;
               launch(CMD_APP);
            end else if (r1 == R1_ILLEGAL) begin
               path = PATH_V1_ACMD;
               launch(CMD_APP);
            end else conclude(1'b0);
         end
         CMD_APP: begin
            if (r1 == R1_IDLE) launch(CMD_APP_OP);
            else op_cond_answer(r1);
         end
         CMD_APP_OP: op_cond_answer(r1);
         CMD_SEND_OP: begin
            if (r1 == R1_IDLE) hold_off();
            else conclude(r1 == R1_READY);
         end
         default: conclude(r1 == R1_READY);
      endcase
   endfunction

   function automatic void take_r1(input logic [7:0] r1);
      // R7 and OCR trailers follow whenever R1 carries no error bits
      if ((cmd == CMD_IF_COND || cmd == CMD_READ_OCR) && r1[7:1] == '0) begin
         seq_state = SQ_TRAIL;
         pcnt = r1;
         fpos = '0;
         put(BYTE_FILL, 1'b1, ST_BUSY);
      end else judge(r1);
   endfunction

   function automatic void step_sequence(input logic [1:0] kind, input logic [7:0] rx);
      logic [7:0] lim;
      got_xfer = 1'b0;
      if (kind == KIND_START) begin
         seq_state = SQ_FILL;
         cmd = '0;
         fpos = '0;
         pcnt = '0;
         dcnt = '0;
         path = PATH_UNKNOWN;
         put(BYTE_FILL, 1'b0, ST_BUSY);
      end else if (kind == KIND_TICK) begin
         if (seq_state == SQ_DELAY) begin
            if (dcnt != 16'hFFFF) dcnt = dcnt + 16'd1;
            if (dcnt >= lim_ticks) retry();
         end
      end else if (kind == KIND_BYTE) begin
         case (seq_state)
            SQ_FILL: begin
               lim = (lim_fill == '0) ? 8'd1 : lim_fill;
               pcnt = pcnt + 8'd1;
               if (pcnt < lim) put(BYTE_FILL, 1'b0, ST_BUSY);
               else begin
                  seq_state = SQ_PRESEL;
                  put(BYTE_FILL, 1'b1, ST_BUSY);
               end
            end
            SQ_PRESEL: begin
               path = PATH_UNKNOWN;
               launch(CMD_GO_IDLE);
            end
            SQ_FRAME: begin
               if (fpos < FRAME_LAST) begin
                  fpos = fpos + 3'd1;
                  put(frame_octet(fpos), 1'b1, ST_BUSY);
               end else begin
                  seq_state = SQ_POLL;
                  pcnt = '0;
                  put(BYTE_FILL, 1'b1, ST_BUSY);
               end
            end
            SQ_POLL: begin
               if (rx != BYTE_FILL) take_r1(rx);
               else begin
                  pcnt = pcnt + 8'd1;
                  // a poll limit of zero behaves as one
                  if (pcnt >= lim_poll) take_r1(BYTE_FILL);
                  else put(BYTE_FILL, 1'b1, ST_BUSY);
               end
            end
            SQ_TRAIL: begin
               fpos = fpos + 3'd1;
               if (fpos < TRAIL_BYTES) put(BYTE_FILL, 1'b1, ST_BUSY);
               else judge(pcnt);
            end
            default: ;
         endcase
      end
   endfunction

   always @(posedge clock) begin
      xfer_t want;
      bit    bad;
      if (reset) begin
         lim_poll = POLL_LIMIT_RST;
         lim_ticks = RETRY_TICKS_RST;
         lim_fill = FILL_BYTES_RST;
         seq_state = SQ_IDLE;
         cmd = '0;
         fpos = '0;
         pcnt = '0;
         dcnt = '0;
         path = PATH_UNKNOWN;
         owed_xfers.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_xfers.size() == 0) begin
               $error("unexpected response: tx_byte %02h select_card %0d status %0d",
                      rsp_mon.tx_byte, rsp_mon.select_card, rsp_mon.status);
               mismatches++;
            end else begin
               want = owed_xfers.pop_front();
               bad = 1'b0;
               if (rsp_mon.tx_byte !== want.tx_byte) begin
                  $error("tx_byte: expected %02h, got %02h", want.tx_byte, rsp_mon.tx_byte);
                  bad = 1'b1;
               end
               if (rsp_mon.select_card !== want.select_card) begin
                  $error("select_card: expected %0d, got %0d",
                         want.select_card, rsp_mon.select_card);
                  bad = 1'b1;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  bad = 1'b1;
               end
               if (bad) mismatches++;
            end
         end
         if (csr_we) begin
            case (csr_addr)
               REG_POLL_LIMIT:  lim_poll = csr_wdata[7:0];
               REG_RETRY_TICKS: lim_ticks = csr_wdata[15:0];
               REG_FILL_BYTES:  lim_fill = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            step_sequence(req_mon.kind, req_mon.rx_byte);
            if (got_xfer) owed_xfers.push_back(xfer);
         end
      end
      fail_count <= mismatches;
      pending <= owed_xfers.size();
   end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the SD SPI init sequencer with start, received-byte and tick
// requests, mostly complete init conversations with a randomly behaving card
// plus stray and broken traffic, across several csr settings. Both channels
// idle at random; prediction and comparison happen in sdi_init_check.
// ----------------------------------------------------------------------------
module tb;
   import sdi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_STRAY = 2'd3;
   localparam int         CYCLE_LIMIT = 1_000_000;
   localparam int         RANDOM_REQS = 220;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;

   // stimulus knobs
   logic [7:0]  cfg_poll;
   logic [15:0] cfg_ticks;
   logic [7:0]  cfg_fill;
   bit          steady = 1'b0;
   bit          eager_card = 1'b0;
   bit          squeeze = 1'b0;
   bit          squeezed = 1'b0;
   int          max_rounds = 3;
   int          sent = 0;
   int          cycles = 0;

   sdi_req_if req_ch ();
   sdi_rsp_if rsp_ch ();

   sd_spi_init_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_ch),
      .rsp_chan  (rsp_ch),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   sdi_init_check u_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int n;
      bit lvl;
      forever begin
         if (squeeze && !squeezed) begin
            squeezed = 1'b1;
            lvl = 1'b0;
            n = 300;
         end else if (steady) begin
            lvl = 1'b1;
            n = 1;
         end else if ($urandom_range(0, 99) < 30) begin
            lvl = 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         end else begin
            lvl = 1'b1;
            n = $urandom_range(1, 8);
         end
         rsp_ch.ready <= lvl;
         repeat (n) @(posedge clock);
      end
   end

   task automatic push_req(input logic [1:0] kind, input logic [7:0] rx);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.rx_byte <= rx;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   task automatic byte_burst(input int n);
      repeat (n) begin
         if ($urandom_range(0, 99) < 3)
            push_req($urandom_range(0, 1) ? KIND_TICK : KIND_STRAY,
                     8'($urandom_range(0, 255)));
         push_req(KIND_BYTE, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] p, input logic [15:0] t, input logic [7:0] f);
      csr_we <= 1'b1;
      csr_addr <= REG_POLL_LIMIT;
      csr_wdata <= {8'h00, p};
      @(posedge clock);
      csr_addr <= REG_RETRY_TICKS;
      csr_wdata <= t;
      @(posedge clock);
      csr_addr <= REG_FILL_BYTES;
      csr_wdata <= {8'h00, f};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_poll = p;
      cfg_ticks = t;
      cfg_fill = f;
   endtask

   // a bad answer: often silence (poll timeout), else any byte
   function automatic logic [7:0] odd_r1();
      if ($urandom_range(0, 9) < 3) return BYTE_FILL;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] op_answer(input int rounds);
      int r;
      r = $urandom_range(0, 99);
      if (eager_card && rounds == 0) return R1_IDLE;
      if (rounds < max_rounds && r < 40) return R1_IDLE;
      r = $urandom_range(0, 99);
      if (r < 70) return R1_READY;
      if (r < 85) return R1_ILLEGAL;
      return odd_r1();
   endfunction

   // filler polls then the R1 byte; an all-0xFF answer runs out the poll limit
   task automatic poll_answer(input logic [7:0] r1);
      int lim;
      int k;
      lim = (cfg_poll == '0) ? 1 : cfg_poll;
      if (r1 == BYTE_FILL) k = lim;
      else if ($urandom_range(0, 19) == 0) k = lim - 1;
      else k = $urandom_range(0, (lim - 1 < 3) ? lim - 1 : 3);
      repeat (k) push_req(KIND_BYTE, BYTE_FILL);
      if (r1 != BYTE_FILL) push_req(KIND_BYTE, r1);
   endtask

   task automatic command(input logic [5:0] cmd, input logic [7:0] r1);
      byte_burst(6);
      poll_answer(r1);
      if ((cmd == CMD_IF_COND || cmd == CMD_READ_OCR) && r1[7:1] == '0) byte_burst(4);
   endtask

   task automatic retry_wait();
      repeat (cfg_ticks) begin
         if (!eager_card && $urandom_range(0, 9) == 0)
            push_req(KIND_BYTE, 8'($urandom_range(0, 255)));
         push_req(KIND_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   // one init conversation with a card that answers at random
   task automatic run_init();
      int         rounds;
      int         r;
      logic [1:0] card;
      logic [7:0] r1;
      bit         busy;
      push_req(KIND_START, 8'($urandom_range(0, 255)));
      byte_burst(((cfg_fill == '0) ? 1 : cfg_fill) + 1);
      r1 = (eager_card || $urandom_range(0, 9) < 8) ? R1_IDLE : odd_r1();
      command(CMD_GO_IDLE, r1);
      if (r1 != R1_IDLE) return;
      r = $urandom_range(0, 9);
      if (eager_card) r1 = (r < 5) ? R1_IDLE : R1_ILLEGAL;
      else if (r < 5) r1 = R1_IDLE;
      else if (r < 8) r1 = R1_ILLEGAL;
      else if (r < 9) r1 = R1_READY;
      else r1 = odd_r1();
      command(CMD_IF_COND, r1);
      if (r1 == R1_IDLE) card = PATH_V2;
      else if (r1 == R1_ILLEGAL) card = PATH_V1_ACMD;
      else return;
      rounds = 0;
      busy = 1'b1;
      while (busy) begin
         if (card == PATH_V1_CMD1) begin
            r1 = op_answer(rounds);
            command(CMD_SEND_OP, r1);
         end else begin
            r1 = (eager_card || $urandom_range(0, 99) < 85) ? R1_IDLE : op_answer(rounds);
            command(CMD_APP, r1);
            if (r1 == R1_IDLE) begin
               r1 = op_answer(rounds);
               command(CMD_APP_OP, r1);
            end
         end
         if (r1 == R1_IDLE) begin
            retry_wait();
            rounds++;
         end else if (card == PATH_V1_ACMD && r1 == R1_ILLEGAL) card = PATH_V1_CMD1;
         else busy = 1'b0;
      end
      if (card == PATH_V2 && r1 == R1_READY) begin
         r = $urandom_range(0, 99);
         if (r < 75) r1 = R1_READY;
         else if (r < 88) r1 = R1_IDLE;
         else r1 = odd_r1();
         command(CMD_READ_OCR, r1);
      end
   endtask

   initial begin
      int base;
      int phase_end;
      int pick;
      req_ch.valid <= 1'b0;
      req_ch.kind <= KIND_START;
      req_ch.rx_byte <= '0;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // zero poll limit and fill count, retry without delay
      set_config(8'd0, 16'd0, 8'd0);
      push_req(KIND_BYTE, 8'h00);
      push_req(KIND_TICK, 8'hFF);
      push_req(KIND_STRAY, 8'hFF);
      push_req(KIND_START, 8'h00);
      push_req(KIND_BYTE, 8'hFF);
      push_req(KIND_START, 8'hA5);
      repeat (8) push_req(KIND_BYTE, 8'($urandom_range(0, 255)));
      push_req(KIND_BYTE, BYTE_FILL);
      push_req(KIND_BYTE, 8'h00);
      push_req(KIND_TICK, 8'h00);
      repeat (2) run_init();
      settle();

      // one-tick retry delay, first with a card that is still busy once
      set_config(8'd1, 16'd1, 8'd1);
      eager_card = 1'b1;
      max_rounds = 1;
      run_init();
      eager_card = 1'b0;
      max_rounds = 0;
      run_init();
      settle();

      // largest settings, gap free: a start and part of the fill
      steady = 1'b1;
      set_config(8'd255, 16'd65535, 8'd255);
      push_req(KIND_START, 8'h00);
      byte_burst(10);
      settle();

      max_rounds = 3;
      base = sent;
      while (sent - base < RANDOM_REQS) begin
         steady = ($urandom_range(0, 3) == 0);
         set_config(($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(1, 6)),
                    16'($urandom_range(0, 4)), 8'($urandom_range(0, 5)));
         phase_end = sent + 60;
         while (sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) run_init();
            else if (pick < 85) begin
               repeat ($urandom_range(3, 10))
                  push_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
               push_req(KIND_START, 8'($urandom_range(0, 255)));
               byte_burst($urandom_range(1, 20));
            end
            if (sent - base > 60) squeeze = 1'b1;
         end
         settle();
      end

      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
